@@ src/dac_pkg.sv @@
// Shared types, constants and angle table for the DEM aspect classifier.
package dac_pkg;

  localparam int ELEV_BITS          = 24;
  localparam int CORDIC_STAGES_DEF  = 18;
  localparam int GRAD_W             = ELEV_BITS + 3;
  localparam int PRESCALE           = 56 - ELEV_BITS;
  localparam int FRAC               = 28;
  localparam int CORDIC_W           = GRAD_W + PRESCALE + 2;
  localparam int ANGLE_W            = 46;
  localparam int CD_W               = 16;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NULL_ELEV   = CFG_IDX_W'(1);

  localparam logic [1:0] MODE_STEEP = 2'd1;
  localparam logic [1:0] MODE_HORN  = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_STEEP;
  localparam logic signed [ELEV_BITS-1:0] NULL_RESET = -ELEV_BITS'(9999);

  localparam logic [7:0] CODE_NE   = 8'd1;
  localparam logic [7:0] CODE_E    = 8'd2;
  localparam logic [7:0] CODE_SE   = 8'd4;
  localparam logic [7:0] CODE_S    = 8'd8;
  localparam logic [7:0] CODE_SW   = 8'd16;
  localparam logic [7:0] CODE_W    = 8'd32;
  localparam logic [7:0] CODE_NW   = 8'd64;
  localparam logic [7:0] CODE_N    = 8'd128;
  localparam logic [7:0] CLASS_FLAT = 8'd255;
  localparam logic [7:0] CLASS_NULL = 8'd0;

  localparam logic signed [ANGLE_W-1:0] Q_DEG90  = ANGLE_W'(64'd9000 << FRAC);
  localparam logic signed [ANGLE_W-1:0] Q_DEG180 = ANGLE_W'(64'd18000 << FRAC);
  localparam logic signed [ANGLE_W-1:0] Q_DEG450 = ANGLE_W'(64'd45000 << FRAC);
  localparam logic signed [ANGLE_W-1:0] Q_HALF   = ANGLE_W'(64'd1 << (FRAC - 1));
  localparam logic [CD_W-1:0]           CD_FULL  = CD_W'(36000);

  localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
  localparam logic [63:0] CD_PER_RAD_Q20 = 64'd6007897930;

  typedef struct packed {
    logic signed [ELEV_BITS-1:0] elev_center;
    logic signed [ELEV_BITS-1:0] elev_west;
    logic signed [ELEV_BITS-1:0] elev_east;
    logic signed [ELEV_BITS-1:0] elev_north;
    logic signed [ELEV_BITS-1:0] elev_south;
    logic signed [ELEV_BITS-1:0] elev_northeast;
    logic signed [ELEV_BITS-1:0] elev_northwest;
    logic signed [ELEV_BITS-1:0] elev_southwest;
    logic signed [ELEV_BITS-1:0] elev_southeast;
  } in_t;

  typedef struct packed {
    logic [7:0]      aspect_class;
    logic [CD_W-1:0] aspect_centideg;
    logic            is_null;
  } out_t;

  // Per-item sideband that rides along the rotation chain
  typedef struct packed {
    logic       is_null;
    logic [1:0] mode;
    logic [7:0] cls;
  } side_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANGLE_W-1:0]  z;
    logic                       freeze;
  } rot_t;

  // atan(2^-idx) in centidegrees with FRAC fraction bits, from a Q62 series
  function automatic logic [63:0] stage_angle(input int idx);
    logic [63:0] r;
    r = 64'd0;
    if (idx == 0) begin
      r = PI_Q60;
    end else begin
      if (1 * idx <= 62)  r = r + ((64'd1 << (62 - 1 * idx)) / 64'd1);
      if (3 * idx <= 62)  r = r - ((64'd1 << (62 - 3 * idx)) / 64'd3);
      if (5 * idx <= 62)  r = r + ((64'd1 << (62 - 5 * idx)) / 64'd5);
      if (7 * idx <= 62)  r = r - ((64'd1 << (62 - 7 * idx)) / 64'd7);
      if (9 * idx <= 62)  r = r + ((64'd1 << (62 - 9 * idx)) / 64'd9);
      if (11 * idx <= 62) r = r - ((64'd1 << (62 - 11 * idx)) / 64'd11);
      if (13 * idx <= 62) r = r + ((64'd1 << (62 - 13 * idx)) / 64'd13);
      if (15 * idx <= 62) r = r - ((64'd1 << (62 - 15 * idx)) / 64'd15);
      if (17 * idx <= 62) r = r + ((64'd1 << (62 - 17 * idx)) / 64'd17);
      if (19 * idx <= 62) r = r - ((64'd1 << (62 - 19 * idx)) / 64'd19);
      if (21 * idx <= 62) r = r + ((64'd1 << (62 - 21 * idx)) / 64'd21);
      if (23 * idx <= 62) r = r - ((64'd1 << (62 - 23 * idx)) / 64'd23);
      if (25 * idx <= 62) r = r + ((64'd1 << (62 - 25 * idx)) / 64'd25);
      if (27 * idx <= 62) r = r - ((64'd1 << (62 - 27 * idx)) / 64'd27);
      if (29 * idx <= 62) r = r + ((64'd1 << (62 - 29 * idx)) / 64'd29);
      if (31 * idx <= 62) r = r - ((64'd1 << (62 - 31 * idx)) / 64'd31);
      if (33 * idx <= 62) r = r + ((64'd1 << (62 - 33 * idx)) / 64'd33);
      if (35 * idx <= 62) r = r - ((64'd1 << (62 - 35 * idx)) / 64'd35);
      if (37 * idx <= 62) r = r + ((64'd1 << (62 - 37 * idx)) / 64'd37);
      if (39 * idx <= 62) r = r - ((64'd1 << (62 - 39 * idx)) / 64'd39);
      if (41 * idx <= 62) r = r + ((64'd1 << (62 - 41 * idx)) / 64'd41);
      if (43 * idx <= 62) r = r - ((64'd1 << (62 - 43 * idx)) / 64'd43);
      if (45 * idx <= 62) r = r + ((64'd1 << (62 - 45 * idx)) / 64'd45);
      if (47 * idx <= 62) r = r - ((64'd1 << (62 - 47 * idx)) / 64'd47);
      if (49 * idx <= 62) r = r + ((64'd1 << (62 - 49 * idx)) / 64'd49);
      if (51 * idx <= 62) r = r - ((64'd1 << (62 - 51 * idx)) / 64'd51);
      if (53 * idx <= 62) r = r + ((64'd1 << (62 - 53 * idx)) / 64'd53);
      if (55 * idx <= 62) r = r - ((64'd1 << (62 - 55 * idx)) / 64'd55);
      if (57 * idx <= 62) r = r + ((64'd1 << (62 - 57 * idx)) / 64'd57);
      if (59 * idx <= 62) r = r - ((64'd1 << (62 - 59 * idx)) / 64'd59);
      if (61 * idx <= 62) r = r + ((64'd1 << (62 - 61 * idx)) / 64'd61);
    end
    return ((r >> 34) * CD_PER_RAD_Q20) >> 20;
  endfunction

  function automatic logic [7:0] sector_class(input logic [CD_W-1:0] cd);
    logic [7:0] c;
    if (cd < CD_W'(2250))       c = CODE_N;
    else if (cd < CD_W'(6750))  c = CODE_NE;
    else if (cd < CD_W'(11250)) c = CODE_E;
    else if (cd < CD_W'(15750)) c = CODE_SE;
    else if (cd < CD_W'(20250)) c = CODE_S;
    else if (cd < CD_W'(24750)) c = CODE_SW;
    else if (cd < CD_W'(29250)) c = CODE_W;
    else if (cd < CD_W'(33750)) c = CODE_NW;
    else                        c = CODE_N;
    return c;
  endfunction

endpackage

@@ src/dem_aspect_classifier_core.sv @@
// Top level of the DEM aspect classifier: config registers, stage chain and flow control.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+------------------------------
//   in      | in        | in_valid_i/in_stall_o | one 3x3 window (dac_pkg::in_t)
//   out     | out       | out_valid_o/out_stall_i | class, centidegrees, null flag
//   cfg     | in        | cfg_valid_i/cfg_ready_o | register index and data
//
// One window per cycle while the chain does not stall; a beat passes CORDIC_STAGES + 4
// registers (the gradient stage, the fold stage, one CORDIC cell per rotation and two
// finishing stages) before it shows on the output. Reset loads aspect_mode 1
// and null_elevation -9999 and empties the chain. A stage holds while its successor
// is full and stalled, so bubbles close up and a new beat enters while a result
// waits at the output.
module dem_aspect_classifier_core #(
  parameter int CORDIC_STAGES = dac_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dac_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dac_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dac_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dac_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int NST = CORDIC_STAGES + 4;
  localparam int EW  = dac_pkg::ELEV_BITS;
  localparam int GW  = dac_pkg::GRAD_W;

  logic [1:0]           mode_q;
  logic signed [EW-1:0] null_q;
  logic [NST-1:0]       valid_q;
  logic [NST:0]         ready;

  logic signed [GW-1:0] gx, gy;
  dac_pkg::side_t       side_g;
  dac_pkg::rot_t        rot   [CORDIC_STAGES+1];
  dac_pkg::side_t       side_c[CORDIC_STAGES+1];

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dac_pkg::MODE_RESET;
      null_q <= dac_pkg::NULL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dac_pkg::REG_ASPECT_MODE: mode_q <= cfg_data_i[1:0];
        dac_pkg::REG_NULL_ELEV:   null_q <= EW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // flow control: a stage advances when it is empty or its successor advances
  always_comb begin
    ready[NST] = !out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NST-1];

  dac_grad u_grad (
    .clk_i       (clk_i),
    .en_i        (ready[0]),
    .in_i        (in_data_i),
    .mode_i      (mode_q),
    .null_elev_i (null_q),
    .x_o         (gx),
    .y_o         (gy),
    .side_o      (side_g)
  );

  dac_prep u_prep (
    .clk_i  (clk_i),
    .en_i   (ready[1]),
    .x_i    (gx),
    .y_i    (gy),
    .side_i (side_g),
    .rot_o  (rot[0]),
    .side_o (side_c[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    dac_cordic_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (ready[g+2]),
      .rot_i  (rot[g]),
      .side_i (side_c[g]),
      .rot_o  (rot[g+1]),
      .side_o (side_c[g+1])
    );
  end

  dac_post u_post (
    .clk_i   (clk_i),
    .en_i    (ready[NST-1:NST-2]),
    .theta_i (rot[CORDIC_STAGES].z),
    .side_i  (side_c[CORDIC_STAGES]),
    .out_o   (out_data_o)
  );

  // a null centre carries no angle and no class
  a_null_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_null |->
      out_data_o.aspect_class == dac_pkg::CLASS_NULL && out_data_o.aspect_centideg == '0)
    else $error("null result carries class or angle");

  a_cd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.aspect_centideg < dac_pkg::CD_FULL)
    else $error("centidegrees out of range");

  // a nonzero angle only comes from the gradient path, which always gives a sector
  a_sector_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.aspect_centideg != '0 |-> $onehot(out_data_o.aspect_class))
    else $error("angle without a sector code");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && !ready[1] |=> valid_q[0])
    else $error("first stage dropped a beat while blocked");

endmodule

@@ src/dac_grad.sv @@
// First stage: Horn gradients, null check and steepest-drop class.
module dac_grad (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  dac_pkg::in_t                         in_i,
  input  logic [1:0]                           mode_i,
  input  logic signed [dac_pkg::ELEV_BITS-1:0] null_elev_i,
  output logic signed [dac_pkg::GRAD_W-1:0]    x_o,
  output logic signed [dac_pkg::GRAD_W-1:0]    y_o,
  output dac_pkg::side_t                       side_o
);

  localparam int EW = dac_pkg::ELEV_BITS;
  localparam int GW = dac_pkg::GRAD_W;

  logic signed [GW-1:0] w, e, n, s, ne, nw, sw, se;
  logic signed [GW-1:0] x_d, y_d, x_q, y_q;
  logic signed [EW-1:0] nb [8];
  logic [7:0]           codes [8];
  logic signed [EW:0]   best, diff;
  logic [7:0]           steep_cls;
  dac_pkg::side_t       side_d, side_q;

  always_comb begin
    w  = GW'(in_i.elev_west);
    e  = GW'(in_i.elev_east);
    n  = GW'(in_i.elev_north);
    s  = GW'(in_i.elev_south);
    ne = GW'(in_i.elev_northeast);
    nw = GW'(in_i.elev_northwest);
    sw = GW'(in_i.elev_southwest);
    se = GW'(in_i.elev_southeast);
    // X is the negated east-west gradient, Y the south-north one
    x_d = (nw + (w <<< 1) + sw) - (ne + (e <<< 1) + se);
    y_d = (sw + (s <<< 1) + se) - (nw + (n <<< 1) + ne);
  end

  always_comb begin
    nb[0] = in_i.elev_west;      codes[0] = dac_pkg::CODE_W;
    nb[1] = in_i.elev_east;      codes[1] = dac_pkg::CODE_E;
    nb[2] = in_i.elev_north;     codes[2] = dac_pkg::CODE_N;
    nb[3] = in_i.elev_south;     codes[3] = dac_pkg::CODE_S;
    nb[4] = in_i.elev_northeast; codes[4] = dac_pkg::CODE_NE;
    nb[5] = in_i.elev_northwest; codes[5] = dac_pkg::CODE_NW;
    nb[6] = in_i.elev_southwest; codes[6] = dac_pkg::CODE_SW;
    nb[7] = in_i.elev_southeast; codes[7] = dac_pkg::CODE_SE;
    best      = '0;
    diff      = '0;
    steep_cls = dac_pkg::CLASS_FLAT;
    // strict compare keeps the first neighbour on a tie
    for (int k = 0; k < 8; k++) begin
      diff = (EW + 1)'(in_i.elev_center) - (EW + 1)'(nb[k]);
      if (diff > best) begin
        best      = diff;
        steep_cls = codes[k];
      end
    end
  end

  always_comb begin
    side_d.is_null = (in_i.elev_center == null_elev_i);
    side_d.mode    = mode_i;
    if (side_d.is_null) begin
      side_d.cls = dac_pkg::CLASS_NULL;
    end else if (mode_i == dac_pkg::MODE_STEEP) begin
      side_d.cls = steep_cls;
    end else begin
      side_d.cls = dac_pkg::CLASS_FLAT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      side_q <= side_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign side_o = side_q;

endmodule

@@ src/dac_prep.sv @@
// Second stage: axis shortcuts, half-plane fold and prescale ahead of the rotations.
module dac_prep (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [dac_pkg::GRAD_W-1:0] x_i,
  input  logic signed [dac_pkg::GRAD_W-1:0] y_i,
  input  dac_pkg::side_t                    side_i,
  output dac_pkg::rot_t                     rot_o,
  output dac_pkg::side_t                    side_o
);

  localparam int GW = dac_pkg::GRAD_W;
  localparam int CW = dac_pkg::CORDIC_W;

  logic signed [GW:0] xw, yw, xs, ys;
  dac_pkg::rot_t      rot_d, rot_q;
  dac_pkg::side_t     side_q;

  always_comb begin
    xw = (GW + 1)'(x_i);
    yw = (GW + 1)'(y_i);
    xs = xw;
    ys = yw;
    rot_d.freeze = 1'b0;
    rot_d.z      = '0;
    if (y_i == '0) begin
      rot_d.freeze = 1'b1;
      rot_d.z      = (x_i > GW'(0)) ? '0 : dac_pkg::Q_DEG180;
    end else if (x_i == '0) begin
      rot_d.freeze = 1'b1;
      rot_d.z      = (y_i > GW'(0)) ? dac_pkg::Q_DEG90 : -dac_pkg::Q_DEG90;
    end else if (x_i < GW'(0)) begin
      // fold into the right half-plane, add half a turn
      xs      = -xw;
      ys      = -yw;
      rot_d.z = dac_pkg::Q_DEG180;
    end
    rot_d.x = CW'(xs) <<< dac_pkg::PRESCALE;
    rot_d.y = CW'(ys) <<< dac_pkg::PRESCALE;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q  <= rot_d;
      side_q <= side_i;
    end
  end

  assign rot_o  = rot_q;
  assign side_o = side_q;

endmodule

@@ src/dac_cordic_cell.sv @@
// One vectoring CORDIC cell: a single rotation toward the x axis per cycle while enabled, none for a frozen beat.
module dac_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  dac_pkg::rot_t  rot_i,
  input  dac_pkg::side_t side_i,
  output dac_pkg::rot_t  rot_o,
  output dac_pkg::side_t side_o
);

  localparam int CW = dac_pkg::CORDIC_W;
  localparam int AW = dac_pkg::ANGLE_W;
  localparam logic signed [AW-1:0] ANGLE = AW'(dac_pkg::stage_angle(IDX));

  logic signed [CW-1:0] x, y, xs, ys;
  logic signed [AW-1:0] z;
  dac_pkg::rot_t        rot_d, rot_q;
  dac_pkg::side_t       side_q;

  always_comb begin
    x  = rot_i.x;
    y  = rot_i.y;
    z  = rot_i.z;
    xs = x >>> IDX;
    ys = y >>> IDX;
    rot_d = rot_i;
    if (!rot_i.freeze) begin
      if (y > CW'(0)) begin
        rot_d.x = x + ys;
        rot_d.y = y - xs;
        rot_d.z = z + ANGLE;
      end else begin
        rot_d.x = x - ys;
        rot_d.y = y + xs;
        rot_d.z = z - ANGLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q  <= rot_d;
      side_q <= side_i;
    end
  end

  assign rot_o  = rot_q;
  assign side_o = side_q;

endmodule

@@ src/dac_post.sv @@
// Last two stages: map to north-based angle, round to centidegrees, pick the sector in Horn mode, else pass the class.
module dac_post (
  input  logic                               clk_i,
  input  logic [1:0]                         en_i,
  input  logic signed [dac_pkg::ANGLE_W-1:0] theta_i,
  input  dac_pkg::side_t                     side_i,
  output dac_pkg::out_t                      out_o
);

  localparam int AW = dac_pkg::ANGLE_W;
  localparam int CDW = dac_pkg::CD_W;
  localparam int FR = dac_pkg::FRAC;

  logic signed [AW-1:0] cell0, cell1, cell_d, cell_q, rnd;
  logic [CDW-1:0]       cd_raw, cd;
  dac_pkg::side_t       side_q;
  dac_pkg::out_t        out_d, out_q;

  always_comb begin
    cell0  = dac_pkg::Q_DEG90 - theta_i;
    cell1  = dac_pkg::Q_DEG450 - theta_i;
    // theta stays within a half turn of 90 degrees, so one wrap suffices
    cell_d = cell0[AW-1] ? cell1 : cell0;
  end

  always_comb begin
    rnd    = cell_q + dac_pkg::Q_HALF;
    cd_raw = rnd[FR+CDW-1:FR];
    cd     = (cd_raw == dac_pkg::CD_FULL) ? '0 : cd_raw;
    out_d.is_null = side_q.is_null;
    if (!side_q.is_null && side_q.mode == dac_pkg::MODE_HORN) begin
      out_d.aspect_class    = dac_pkg::sector_class(cd);
      out_d.aspect_centideg = cd;
    end else begin
      out_d.aspect_class    = side_q.cls;
      out_d.aspect_centideg = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cell_q <= cell_d;
      side_q <= side_i;
    end
    if (en_i[1]) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

@@ tb/tb_dem_aspect_classifier_core.sv @@
// Self-checking testbench for dem_aspect_classifier_core: directed and random windows against a local aspect model.
module tb_dem_aspect_classifier_core;
  import dac_pkg::*;

  localparam int ROT_STAGES   = CORDIC_STAGES_DEF;
  localparam int LATENCY      = ROT_STAGES + 4;
  localparam int PRE_SHIFT    = 56 - ELEV_BITS;
  localparam int FRAC_Q       = 28;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 500000;
  localparam int ELEV_MIN     = -8388608;
  localparam int ELEV_MAX     = 8388607;

  localparam longint CD90_Q  = 64'sd9000 <<< FRAC_Q;
  localparam longint CD180_Q = 64'sd18000 <<< FRAC_Q;
  localparam longint CD360_Q = 64'sd36000 <<< FRAC_Q;
  localparam longint HALF_Q  = 64'sd1 <<< (FRAC_Q - 1);
  localparam longint NULL_AT_RESET = -9999;

  localparam longint unsigned ATAN0_Q60     = 64'h3243F6A8885A308D;
  localparam longint unsigned RAD_TO_CD_Q20 = 64'd6007897930;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bit hold_req = 1'b0;

  dem_aspect_classifier_core #(
    .CORDIC_STAGES(ROT_STAGES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  class aspect_scoreboard;
    logic [1:0] mode_q;
    longint     null_q;
    longint     atan_q[ROT_STAGES];
    out_t       pending[$];
    int         errors;

    function new();
      longint unsigned r, t;
      int i, k, n;
      mode_q = MODE_STEEP;
      null_q = NULL_AT_RESET;
      errors = 0;
      // atan(2^-i) in centidegrees, Q28, from a Q62 arctangent series
      for (i = 0; i < ROT_STAGES; i++) begin
        if (i == 0) begin
          r = ATAN0_Q60;
        end else begin
          r = 64'd0;
          for (k = 0; (2 * k + 1) * i <= 62; k++) begin
            n = 2 * k + 1;
            t = (64'd1 << (62 - n * i)) / longint'(n);
            if (k % 2 == 1) r = r - t;
            else r = r + t;
          end
        end
        atan_q[i] = longint'(((r >> 34) * RAD_TO_CD_Q20) >> 20);
      end
    endfunction

    function void write_register(logic [1:0] idx, logic [23:0] data);
      if (idx == REG_ASPECT_MODE) mode_q = data[1:0];
      else if (idx == REG_NULL_ELEV) null_q = $signed(data);
    endfunction

    function longint horn_angle(longint x, longint y);
      longint ang, xs, ys;
      int i;
      ang = 0;
      if (y == 0) return (x > 0) ? 64'sd0 : CD180_Q;
      if (x == 0) return (y > 0) ? CD90_Q : -CD90_Q;
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = CD180_Q;
      end
      x = x <<< PRE_SHIFT;
      y = y <<< PRE_SHIFT;
      for (i = 0; i < ROT_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          ang = ang + atan_q[i];
        end else begin
          x = x - ys;
          y = y + xs;
          ang = ang - atan_q[i];
        end
      end
      return ang;
    endfunction

    function logic [7:0] sector_code(longint cd);
      if (cd < 2250) return CODE_N;
      if (cd < 6750) return CODE_NE;
      if (cd < 11250) return CODE_E;
      if (cd < 15750) return CODE_SE;
      if (cd < 20250) return CODE_S;
      if (cd < 24750) return CODE_SW;
      if (cd < 29250) return CODE_W;
      if (cd < 33750) return CODE_NW;
      return CODE_N;
    endfunction

    function logic [7:0] dir_code(int k);
      case (k)
        0: return CODE_W;
        1: return CODE_E;
        2: return CODE_N;
        3: return CODE_S;
        4: return CODE_NE;
        5: return CODE_NW;
        6: return CODE_SW;
        default: return CODE_SE;
      endcase
    endfunction

    function out_t predict_aspect(in_t w);
      out_t   r;
      longint c, best, d, gx, gy, north_ang, cd;
      longint nb[8];
      int     k;
      c = $signed(w.elev_center);
      nb[0] = $signed(w.elev_west);
      nb[1] = $signed(w.elev_east);
      nb[2] = $signed(w.elev_north);
      nb[3] = $signed(w.elev_south);
      nb[4] = $signed(w.elev_northeast);
      nb[5] = $signed(w.elev_northwest);
      nb[6] = $signed(w.elev_southwest);
      nb[7] = $signed(w.elev_southeast);
      r = '0;
      if (c == null_q) begin
        r.aspect_class = CLASS_NULL;
        r.is_null = 1'b1;
        return r;
      end
      r.aspect_class = CLASS_FLAT;
      if (mode_q == MODE_STEEP) begin
        // strict compare keeps the first neighbor on a tie
        best = 0;
        for (k = 0; k < 8; k++) begin
          d = c - nb[k];
          if (d > best) begin
            best = d;
            r.aspect_class = dir_code(k);
          end
        end
      end else if (mode_q == MODE_HORN) begin
        gx = (nb[4] + 2 * nb[1] + nb[7]) - (nb[5] + 2 * nb[0] + nb[6]);
        gy = (nb[6] + 2 * nb[3] + nb[7]) - (nb[5] + 2 * nb[2] + nb[4]);
        north_ang = CD90_Q - horn_angle(-gx, gy);
        while (north_ang < 0) north_ang = north_ang + CD360_Q;
        while (north_ang >= CD360_Q) north_ang = north_ang - CD360_Q;
        cd = (north_ang + HALF_Q) >>> FRAC_Q;
        if (cd >= 36000) cd = cd - 36000;
        r.aspect_centideg = cd[15:0];
        r.aspect_class = sector_code(cd);
      end
      return r;
    endfunction

    function void note_window(in_t w);
      pending.push_back(predict_aspect(w));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: aspect_class %0d aspect_centideg %0d is_null %0b",
               got.aspect_class, got.aspect_centideg, got.is_null);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.aspect_class !== want.aspect_class) begin
        $error("aspect_class: expected %0d, actual %0d", want.aspect_class, got.aspect_class);
        errors++;
      end
      if (got.aspect_centideg !== want.aspect_centideg) begin
        $error("aspect_centideg: expected %0d, actual %0d",
               want.aspect_centideg, got.aspect_centideg);
        errors++;
      end
      if (got.is_null !== want.is_null) begin
        $error("is_null: expected %0b, actual %0b", want.is_null, got.is_null);
        errors++;
      end
    endfunction
  endclass

  aspect_scoreboard sb;

  function automatic in_t win(int c, int west, int east, int north, int south,
                              int ne, int nw, int sw, int se);
    in_t r;
    r.elev_center    = c[23:0];
    r.elev_west      = west[23:0];
    r.elev_east      = east[23:0];
    r.elev_north     = north[23:0];
    r.elev_south     = south[23:0];
    r.elev_northeast = ne[23:0];
    r.elev_northwest = nw[23:0];
    r.elev_southwest = sw[23:0];
    r.elev_southeast = se[23:0];
    return r;
  endfunction

  function automatic int dip(int k, int j);
    return (k == j) ? 90 : 100;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int extreme_value();
    case ($urandom_range(0, 5))
      0: return ELEV_MIN;
      1: return ELEV_MAX;
      2: return ELEV_MIN + 1;
      3: return ELEV_MAX - 1;
      4: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 4)) - 2;
  endfunction

  function automatic int tiny();
    return int'($urandom_range(0, 2));
  endfunction

  function automatic in_t random_window(logic [23:0] null_e);
    in_t          w;
    logic [223:0] raw;
    int           b, ax, ay, sel;
    sel = $urandom_range(0, 99);
    b = int'($urandom_range(0, 16776000)) - 8388000;
    if (sel < 20) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[215:0];
    end else if (sel < 55) begin
      // planar slope plus a little noise
      ax = int'($urandom_range(0, 100)) - 50;
      ay = int'($urandom_range(0, 100)) - 50;
      w = win(b, b - ax + jitter(), b + ax + jitter(), b - ay + jitter(), b + ay + jitter(),
              b + ax - ay + jitter(), b - ax - ay + jitter(), b - ax + ay + jitter(),
              b + ax + ay + jitter());
    end else if (sel < 75) begin
      w = win(b + tiny(), b + tiny(), b + tiny(), b + tiny(), b + tiny(),
              b + tiny(), b + tiny(), b + tiny(), b + tiny());
    end else if (sel < 90) begin
      w = win(extreme_value(), extreme_value(), extreme_value(), extreme_value(),
              extreme_value(), extreme_value(), extreme_value(), extreme_value(),
              extreme_value());
    end else begin
      w = win(b, b, b, b, b, b, b, b, b);
    end
    if ($urandom_range(0, 9) == 0) w.elev_center = null_e;
    return w;
  endfunction

  task automatic send_window(in_t w, bit steady);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_window(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // leaves valid high so back-to-back writes run without a gap
  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
  endtask

  task automatic configure(logic [1:0] mode, logic [23:0] null_d, bit poke_spare);
    write_reg(REG_NULL_ELEV, null_d);
    write_reg(REG_ASPECT_MODE, {22'($urandom), mode});
    if (poke_spare) write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 24'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver pacing: random stalls, long free stretches, and one long hold-off on request
  initial begin
    int stall_left, free_left;
    stall_left = 0;
    free_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (free_left > 0) begin
          free_left--;
        end else begin
          stall_left = idle_len();
          free_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 8);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int          p, n, k;
    logic [1:0]  mode;
    logic [23:0] null_d;
    bit          steady;
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // steepest drop with reset settings
    send_window(win(100, 100, 100, 100, 100, 100, 100, 100, 100), 1'b0);
    send_window(win(-9999, 5, -3, 7, 0, 1, 2, 3, 4), 1'b0);
    for (k = 0; k < 8; k++)
      send_window(win(100, dip(k, 0), dip(k, 1), dip(k, 2), dip(k, 3),
                      dip(k, 4), dip(k, 5), dip(k, 6), dip(k, 7)), 1'b0);
    send_window(win(50, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_window(win(0, 0, -5, 0, 0, 0, 0, 0, -5), 1'b0);
    send_window(win(ELEV_MAX, ELEV_MIN, ELEV_MIN, ELEV_MIN, ELEV_MIN,
                    ELEV_MIN, ELEV_MIN, ELEV_MIN, ELEV_MIN), 1'b0);
    send_window(win(ELEV_MIN, ELEV_MAX, ELEV_MAX, ELEV_MAX, ELEV_MAX,
                    ELEV_MAX, ELEV_MAX, ELEV_MAX, ELEV_MAX), 1'b0);
    send_window(win(0, -1, 0, 0, 0, 0, 0, 0, -7), 1'b0);
    drain();

    // Horn gradients: flat, null, axis vectors, extremes
    configure(MODE_HORN, 24'(-9999), 1'b0);
    send_window(win(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_window(win(-9999, 1, 2, 3, 4, 5, 6, 7, 8), 1'b0);
    send_window(win(0, 0, 100, 0, 0, 0, 0, 0, 0), 1'b0);
    send_window(win(0, 100, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    send_window(win(0, 0, 0, 100, 0, 0, 0, 0, 0), 1'b0);
    send_window(win(0, 0, 0, 0, 100, 0, 0, 0, 0), 1'b0);
    send_window(win(0, ELEV_MIN, ELEV_MAX, 0, 0, ELEV_MAX, ELEV_MIN, ELEV_MIN, ELEV_MAX), 1'b0);
    send_window(win(0, 0, 0, 0, 0, ELEV_MAX, 0, ELEV_MIN, 0), 1'b0);
    send_window(win(ELEV_MAX, ELEV_MIN, ELEV_MIN, ELEV_MAX, ELEV_MAX,
                    ELEV_MIN, ELEV_MAX, ELEV_MAX, ELEV_MIN), 1'b0);
    send_window(win(0, 0, 3, 0, 7, 0, 0, 0, 0), 1'b0);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin mode = MODE_STEEP; null_d = 24'h000000; end
        1: begin mode = MODE_HORN;  null_d = 24'h7FFFFF; end
        2: begin mode = MODE_HORN;  null_d = 24'h800000; end
        3: begin mode = MODE_OFF;   null_d = 24'($urandom); end
        4: begin mode = MODE_SPARE; null_d = 24'($urandom); end
        5: begin mode = MODE_STEEP; null_d = 24'h800000; end
        6: begin mode = MODE_STEEP; null_d = 24'h7FFFFF; end
        default: begin
          if ($urandom_range(0, 9) < 8) mode = $urandom_range(0, 1) ? MODE_STEEP : MODE_HORN;
          else mode = 2'($urandom);
          null_d = 24'($urandom);
        end
      endcase
      configure(mode, null_d, p % 2 == 1);
      // back-pressure: hold the output while the input keeps offering beats
      if (p == 2) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        steady = (p == 2 && n < 120) || (p == 7 && n < 60);
        send_window(random_window(sb.null_q[23:0]), steady);
      end
      drain();
    end

    repeat (2 * LATENCY) @(posedge clk_i);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
